// File: hw/rtl/fsdm_pkg.sv
// Shared types and constants for the floored signed divide and remainder block.
// The package has no dependencies. fsdm_front, fsdm_back and the top module import it.
package fsdm_pkg;

    localparam int DATA_WIDTH = 32;

    typedef logic [DATA_WIDTH-1:0] word_t;

    localparam word_t WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef enum logic [1:0]
    {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_OVF  = 2'd2
    } status_t;

    typedef struct packed
    {
        word_t dividend;
        word_t divisor;
    } operands_t;

    typedef struct packed
    {
        word_t   quotient;
        word_t   remainder;
        status_t status;
    } result_t;

    typedef struct packed
    {
        logic  neg_a;
        logic  neg_b;
        logic  div0;
        logic  ovf;
        word_t abs_a;
        word_t abs_b;
    } work_t;

endpackage

// File: hw/rtl/fsdm_fifo.sv
// Small first-word-fall-through queue for any packed payload type.
// Depends on nothing but its type and depth parameters.
module fsdm_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  T     wdata,
    input  logic pop,
    output logic empty,
    output T     rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T                mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count exceeds its depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == CW'($past(count_reg) + 1'b1))
        else $error("queue count did not grow on a lone transfer in");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CW'(1) && do_pop && !do_push) |=> empty)
        else $error("queue not empty after its last entry left");

endmodule

// File: hw/rtl/fsdm_front.sv
// Front stage: registers each operand pair and classifies it into signs,
// magnitudes and special cases. Depends on fsdm_pkg.
module fsdm_front
    import fsdm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  operands_t operands,
    output logic      work_valid,
    input  logic      work_ready,
    output work_t     work
);

    logic  valid_reg;
    work_t work_reg;
    work_t work_next;
    logic  ready;

    assign ready      = !valid_reg || work_ready;
    assign full       = !ready;
    assign work_valid = valid_reg;
    assign work       = work_reg;

    always_comb
    begin
        work_next.neg_a = operands.dividend[DATA_WIDTH-1];
        work_next.neg_b = operands.divisor[DATA_WIDTH-1];
        work_next.abs_a = work_next.neg_a ? word_t'(~operands.dividend + 1'b1)
                                          : operands.dividend;
        work_next.abs_b = work_next.neg_b ? word_t'(~operands.divisor + 1'b1)
                                          : operands.divisor;
        work_next.div0  = (operands.divisor == '0);
        work_next.ovf   = (operands.dividend == WORD_MIN) && (operands.divisor == '1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && ready)
        begin
            work_reg <= work_next;
        end
    end

endmodule

// File: hw/rtl/fsdm_back.sv
// Back end: a restoring divider with one quotient bit per stage, followed by
// two stages of floored correction. Depends on fsdm_pkg.
module fsdm_back
    import fsdm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  work_t   work,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t result
);

    localparam int STAGES = DATA_WIDTH;

    typedef struct packed
    {
        logic  neg_a;
        logic  neg_b;
        logic  div0;
        logic  ovf;
        word_t abs_b;
        word_t rem;
        word_t aq;
    } stage_t;

    typedef struct packed
    {
        logic  neg_q;
        logic  fix;
        logic  neg_b;
        logic  div0;
        logic  ovf;
        word_t q;
        word_t mag_r;
    } corr_t;

    function automatic stage_t div_step(input stage_t s);
        logic [DATA_WIDTH:0] shifted;
        logic [DATA_WIDTH:0] diff;
        logic                ge;
        stage_t              n;
        shifted = {s.rem, s.aq[DATA_WIDTH-1]};
        diff    = shifted - {1'b0, s.abs_b};
        ge      = (shifted >= {1'b0, s.abs_b});
        n       = s;
        n.rem   = ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
        n.aq    = {s.aq[DATA_WIDTH-2:0], ge};
        return n;
    endfunction

    stage_t              head;
    stage_t              stage_reg [STAGES];
    stage_t              stage_next [STAGES];
    logic [STAGES-1:0]   stage_valid_reg;
    corr_t               corr_reg;
    corr_t               corr_next;
    logic                corr_valid_reg;
    result_t             res_reg;
    result_t             res_next;
    logic                res_neg_b_reg;
    logic                res_valid_reg;
    logic                adv;
    stage_t              tail;

    assign adv       = !res_valid_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = res_valid_reg;
    assign result    = res_reg;
    assign tail      = stage_reg[STAGES-1];

    always_comb
    begin
        head.neg_a = work.neg_a;
        head.neg_b = work.neg_b;
        head.div0  = work.div0;
        head.ovf   = work.ovf;
        head.abs_b = work.abs_b;
        head.rem   = '0;
        head.aq    = work.abs_a;
    end

    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        if (g == 0)
        begin : g_first
            assign stage_next[g] = div_step(head);
        end
        else
        begin : g_rest
            assign stage_next[g] = div_step(stage_reg[g-1]);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                stage_reg[g] <= stage_next[g];
            end
        end
    end

    always_comb
    begin
        corr_next.neg_q = tail.neg_a != tail.neg_b;
        corr_next.fix   = corr_next.neg_q && (tail.rem != '0);
        corr_next.neg_b = tail.neg_b;
        corr_next.div0  = tail.div0;
        corr_next.ovf   = tail.ovf;
        corr_next.q     = tail.aq;
        corr_next.mag_r = corr_next.fix ? word_t'(tail.abs_b - tail.rem) : tail.rem;
    end

    always_comb
    begin
        if (corr_reg.div0)
        begin
            res_next.quotient  = '0;
            res_next.remainder = '0;
            res_next.status    = ST_DIV0;
        end
        else
        begin
            if (!corr_reg.neg_q)
            begin
                res_next.quotient = corr_reg.q;
            end
            else if (corr_reg.fix)
            begin
                res_next.quotient = ~corr_reg.q;
            end
            else
            begin
                res_next.quotient = word_t'(~corr_reg.q + 1'b1);
            end
            res_next.remainder = corr_reg.neg_b ? word_t'(~corr_reg.mag_r + 1'b1)
                                                : corr_reg.mag_r;
            res_next.status    = corr_reg.ovf ? ST_OVF : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
            corr_valid_reg  <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else if (adv)
        begin
            stage_valid_reg <= {stage_valid_reg[STAGES-2:0], in_valid};
            corr_valid_reg  <= stage_valid_reg[STAGES-1];
            res_valid_reg   <= corr_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            corr_reg      <= corr_next;
            res_reg       <= res_next;
            res_neg_b_reg <= corr_reg.neg_b;
        end
    end

    a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.status == ST_DIV0)
            |-> (res_reg.quotient == '0 && res_reg.remainder == '0))
        else $error("divide by zero result carries nonzero fields");

    a_ovf_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.status == ST_OVF)
            |-> (res_reg.quotient == WORD_MIN && res_reg.remainder == '0))
        else $error("overflow result did not wrap to the most negative value");

    a_rem_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.status == ST_OK && res_reg.remainder != '0)
            |-> (res_reg.remainder[DATA_WIDTH-1] == res_neg_b_reg))
        else $error("remainder sign differs from divisor sign");

endmodule

// File: hw/rtl/floored_signed_divmod_top.sv
// Floored signed divide with remainder: front classifier, queue, pipelined back end, output queue.
// Depends on fsdm_pkg, fsdm_front, fsdm_fifo and fsdm_back.
// The back end has one divider stage per quotient bit.
// Throughput is one transfer per cycle while results are taken as they appear.
// Reset clears the queues and all valid bits; no result is pending after reset.
module floored_signed_divmod_top
    import fsdm_pkg::*;
#(
    parameter int MID_DEPTH = 2,
    parameter int OUT_DEPTH = 2
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  operands_t operands,
    input  logic      pop,
    output logic      empty,
    output result_t   result
);

    logic    front_valid;
    logic    mid_full;
    work_t   front_work;
    logic    mid_empty;
    work_t   mid_work;
    logic    back_ready;
    logic    back_valid;
    result_t back_result;
    logic    out_full;

    fsdm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .operands   (operands),
        .work_valid (front_valid),
        .work_ready (!mid_full),
        .work       (front_work)
    );

    fsdm_fifo #(
        .T     (work_t),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_valid),
        .full  (mid_full),
        .wdata (front_work),
        .pop   (back_ready),
        .empty (mid_empty),
        .rdata (mid_work)
    );

    fsdm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!mid_empty),
        .in_ready  (back_ready),
        .work      (mid_work),
        .out_valid (back_valid),
        .out_ready (!out_full),
        .result    (back_result)
    );

    fsdm_fifo #(
        .T     (result_t),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_valid),
        .full  (out_full),
        .wdata (back_result),
        .pop   (pop),
        .empty (empty),
        .rdata (result)
    );

endmodule

// File: dv/tb_floored_signed_divmod_top.sv
// Self-checking testbench for floored_signed_divmod_top: directed vectors, then random operands.
// Depends on fsdm_pkg for the operand and result types and on the block's RTL.
// Each transfer is checked field by field against a table value or a floored divide predictor.
module tb_floored_signed_divmod_top
    import fsdm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam word_t WORD_MAX = ~WORD_MIN;
    localparam word_t ALL_ONES = '1;
    localparam int LATENCY = DATA_WIDTH + 4;
    localparam int LONG_HOLD = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PER_PHASE = 300;
    localparam int NUM_VECTORS = 24;

    typedef struct packed
    {
        word_t   dividend;
        word_t   divisor;
        logic    known;
        word_t   quotient;
        word_t   remainder;
        status_t status;
    } vector_row_t;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    operands_t operands;
    logic      pop;
    logic      empty;
    result_t   result;

    result_t     pending_results[$];
    vector_row_t vectors [0:NUM_VECTORS-1];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          long_hold_request = 1'b0;

    floored_signed_divmod_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .operands (operands),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic result_t floor_divmod(input operands_t op);
        word_t   a;
        word_t   b;
        word_t   mag_a;
        word_t   mag_b;
        word_t   mag_q;
        word_t   mag_r;
        word_t   q;
        word_t   r;
        logic    neg_a;
        logic    neg_b;
        result_t res;
        a = op.dividend;
        b = op.divisor;
        res.quotient = '0;
        res.remainder = '0;
        res.status = ST_DIV0;
        if (b == '0)
        begin
            return res;
        end
        neg_a = a[DATA_WIDTH-1];
        neg_b = b[DATA_WIDTH-1];
        mag_a = neg_a ? -a : a;
        mag_b = neg_b ? -b : b;
        mag_q = mag_a / mag_b;
        mag_r = mag_a % mag_b;
        q = (neg_a != neg_b) ? -mag_q : mag_q;
        r = neg_a ? -mag_r : mag_r;
        // A truncated remainder against the divisor's sign is pulled across by one divisor.
        if (mag_r != '0 && neg_a != neg_b)
        begin
            r = r + b;
            q = q - word_t'(1);
        end
        res.quotient = q;
        res.remainder = r;
        res.status = (a == WORD_MIN && b == ALL_ONES) ? ST_OVF : ST_OK;
        return res;
    endfunction

    function automatic word_t signed_small(input int span);
        return word_t'($urandom_range(0, 2 * span)) - word_t'(span);
    endfunction

    function automatic operands_t random_operands();
        operands_t op;
        word_t     k;
        op.dividend = word_t'($urandom);
        op.divisor = word_t'($urandom);
        case ($urandom_range(0, 9))
            3:
            begin
                op.dividend = signed_small(20);
                op.divisor = signed_small(20);
            end
            4:
            begin
                op.divisor = signed_small(8);
            end
            5:
            begin
                op.divisor = word_t'($urandom_range(1, 1000));
                if ($urandom_range(0, 1) == 1)
                begin
                    op.divisor = -op.divisor;
                end
                k = signed_small(2000000);
                op.dividend = op.divisor * k;
            end
            6:
            begin
                op.divisor = '0;
            end
            7:
            begin
                case ($urandom_range(0, 3))
                    0: op.dividend = WORD_MIN;
                    1: op.dividend = WORD_MAX;
                    2: op.dividend = '0;
                    default: op.dividend = ALL_ONES;
                endcase
                if ($urandom_range(0, 1) == 1)
                begin
                    op.divisor = ($urandom_range(0, 1) == 1) ? WORD_MIN : WORD_MAX;
                end
            end
            8:
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    op.dividend = WORD_MIN;
                end
                op.divisor = ($urandom_range(0, 1) == 1) ? ALL_ONES : word_t'(1);
            end
            9:
            begin
                op.dividend = op.dividend >> $urandom_range(0, DATA_WIDTH - 1);
                op.divisor = op.divisor >> $urandom_range(0, DATA_WIDTH - 1);
                if ($urandom_range(0, 1) == 1)
                begin
                    op.dividend = -op.dividend;
                end
                if ($urandom_range(0, 1) == 1)
                begin
                    op.divisor = -op.divisor;
                end
            end
            default:
            begin
            end
        endcase
        return op;
    endfunction

    task automatic report_mismatch(input string field, input word_t got, input word_t want);
        mismatch_count++;
        if (mismatch_count <= 50)
        begin
            $display("mismatch in %s at cycle %0d: got %h, expected %h",
                     field, cycle_count, got, want);
        end
    endtask

    task automatic offer_operands(input operands_t op, input result_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        operands <= op;
        do
            @(posedge clk);
        while (full);
        pending_results.push_back(want);
    endtask

    task automatic offer_random(input int count);
        operands_t op;
        repeat (count)
        begin
            op = random_operands();
            offer_operands(op, floor_divmod(op));
        end
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // The receiver decides pop each cycle and counts out any long hold itself.
    initial
    begin
        int hold_left;
        hold_left = 0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_request)
            begin
                long_hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", result.quotient, '0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.quotient != want.quotient)
                begin
                    report_mismatch("quotient", result.quotient, want.quotient);
                end
                if (result.remainder != want.remainder)
                begin
                    report_mismatch("remainder", result.remainder, want.remainder);
                end
                if (result.status != want.status)
                begin
                    report_mismatch("status", word_t'(result.status), word_t'(want.status));
                end
            end
        end
    end

    initial
    begin
        operands_t op;
        result_t   want;
        vectors = '{
            '{'0,              '0,              1'b1, '0,              '0, ST_DIV0},
            '{WORD_MAX,        '0,              1'b1, '0,              '0, ST_DIV0},
            '{WORD_MIN,        '0,              1'b1, '0,              '0, ST_DIV0},
            '{ALL_ONES,        '0,              1'b1, '0,              '0, ST_DIV0},
            '{WORD_MIN,        ALL_ONES,        1'b1, WORD_MIN,        '0, ST_OVF},
            '{WORD_MAX,        word_t'(1),      1'b1, WORD_MAX,        '0, ST_OK},
            '{WORD_MIN,        word_t'(1),      1'b1, WORD_MIN,        '0, ST_OK},
            '{WORD_MAX,        ALL_ONES,        1'b1, WORD_MIN + 1'b1, '0, ST_OK},
            '{'0,              WORD_MIN,        1'b1, '0,              '0, ST_OK},
            '{WORD_MIN,        WORD_MIN,        1'b1, word_t'(1),      '0, ST_OK},
            '{WORD_MAX,        WORD_MAX,        1'b1, word_t'(1),      '0, ST_OK},
            '{ALL_ONES,        ALL_ONES,        1'b1, word_t'(1),      '0, ST_OK},
            '{word_t'(7),      word_t'(2),      1'b0, '0,              '0, ST_OK},
            '{word_t'(-7),     word_t'(2),      1'b0, '0,              '0, ST_OK},
            '{word_t'(7),      word_t'(-2),     1'b0, '0,              '0, ST_OK},
            '{word_t'(-7),     word_t'(-2),     1'b0, '0,              '0, ST_OK},
            '{word_t'(-6),     word_t'(3),      1'b0, '0,              '0, ST_OK},
            '{WORD_MIN,        WORD_MAX,        1'b0, '0,              '0, ST_OK},
            '{WORD_MAX,        WORD_MIN,        1'b0, '0,              '0, ST_OK},
            '{ALL_ONES,        WORD_MIN,        1'b0, '0,              '0, ST_OK},
            '{word_t'(1),      WORD_MIN,        1'b0, '0,              '0, ST_OK},
            '{ALL_ONES,        WORD_MAX,        1'b0, '0,              '0, ST_OK},
            '{WORD_MIN,        word_t'(2),      1'b0, '0,              '0, ST_OK},
            '{word_t'(1),      ALL_ONES,        1'b0, '0,              '0, ST_OK}
        };
        rst_n <= 1'b0;
        push <= 1'b0;
        operands <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 21;
        recv_idle_pct = 50;
        for (int i = 0; i < NUM_VECTORS; i++)
        begin
            op.dividend = vectors[i].dividend;
            op.divisor = vectors[i].divisor;
            if (vectors[i].known)
            begin
                want.quotient = vectors[i].quotient;
                want.remainder = vectors[i].remainder;
                want.status = vectors[i].status;
            end
            else
            begin
                want = floor_divmod(op);
            end
            offer_operands(op, want);
        end
        offer_random(RANDOM_PER_PHASE);
        drain_results();

        send_idle_pct = 50;
        recv_idle_pct = 21;
        offer_random(RANDOM_PER_PHASE);
        drain_results();

        // Hold the receiver off so that the queues fill and full rises.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        long_hold_request = 1'b1;
        offer_random(80);
        offer_random(RANDOM_PER_PHASE - 80);
        drain_results();

        repeat (LATENCY + 12) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/fsdm_pkg.sv
hw/rtl/fsdm_fifo.sv
hw/rtl/fsdm_front.sv
hw/rtl/fsdm_back.sv
hw/rtl/floored_signed_divmod_top.sv
dv/tb_floored_signed_divmod_top.sv
